// ===== rtl/core/mfde_pkg.sv =====
// Shared constants for the monochrome framebuffer draw engine.
// Holds the buffer geometry, derived field widths and command codes.
// No dependencies.
`default_nettype none

package mfde_pkg;

    localparam int MAX_WIDTH    = 128;
    localparam int MAX_HEIGHT   = 64;
    localparam int BUFFER_BYTES = 1024;

    localparam int COORD_W = 12;
    localparam int IMG_W_W = 8;
    localparam int IMG_H_W = 7;

    localparam int X_W     = $clog2(MAX_WIDTH);
    localparam int Y_W     = $clog2(MAX_HEIGHT);
    localparam int BX_W    = X_W - 3;
    localparam int BPR_W   = $clog2(MAX_WIDTH / 8) + 1;
    localparam int RA_W    = Y_W + BPR_W;
    localparam int ADDR_W  = $clog2(BUFFER_BYTES);

    localparam logic [1:0] KIND_FILL  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

endpackage

`default_nettype wire

// ===== rtl/core/mono_framebuffer_draw_engine_unit.sv =====
// Top level of the monochrome 1-bit-per-pixel framebuffer draw engine.
// Holds the frame store, the clip logic and the command sequencer.
// Depends on mfde_pkg.
//
// The engine owns a 1024-byte frame store with rows packed MSB-first. After
// reset it runs a clearing pass over every byte and takes no command until it
// is done. A fill command reads and then writes back each byte its clipped
// rectangle touches, after a setup step; a pixel read fetches one byte, and a
// clear writes the ink value to every byte of the store.
// The store has a single read-modify-write port, which the sequencer walks
// one byte at a time. Each command returns one result transfer, and a new
// command is taken while a result still waits.
`default_nettype none

module mono_framebuffer_draw_engine_unit
    import mfde_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [1:0]          i_kind,
    input  wire  [COORD_W-1:0]  i_pos_x,
    input  wire  [COORD_W-1:0]  i_pos_y,
    input  wire  [COORD_W-1:0]  i_rect_width,
    input  wire  [COORD_W-1:0]  i_rect_height,
    input  wire                 i_ink,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic                o_pixel_value,
    input  wire                 i_cfg_we,
    input  wire  [0:0]          i_cfg_index,
    input  wire  [IMG_W_W-1:0]  i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_PRD   = 3'd4;
    localparam logic [2:0] S_PGET  = 3'd5;
    localparam logic [2:0] S_CLR   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [IMG_W_W-1:0] WMAX      = IMG_W_W'(MAX_WIDTH);
    localparam logic [IMG_H_W-1:0] HMAX      = IMG_H_W'(MAX_HEIGHT);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(BUFFER_BYTES - 1);
    localparam logic [RA_W-1:0]    BUF_SIZE  = RA_W'(BUFFER_BYTES);

    logic [2:0]          r_state;
    logic [IMG_W_W-1:0]  r_img_w;
    logic [IMG_H_W-1:0]  r_img_h;

    logic [1:0]          r_kind;
    t_coord              r_px;
    t_coord              r_py;
    t_coord              r_rw;
    t_coord              r_rh;
    logic                r_ink;

    logic [X_W-1:0]      r_x0;
    logic [X_W-1:0]      r_xl;
    logic [Y_W-1:0]      r_cy;
    logic [Y_W-1:0]      r_yl;
    logic [BX_W-1:0]     r_bx;
    logic [RA_W-1:0]     r_row_base;
    logic                r_pix;
    logic                r_ok;

    logic [ADDR_W-1:0]   r_clr_addr;
    logic [7:0]          r_fill;
    logic                r_clr_result;

    logic                r_out_valid;
    logic                r_out_pix;

    logic [7:0]          r_mem [BUFFER_BYTES];
    logic [7:0]          r_rdata;

    logic [IMG_W_W-1:0]  w_wuse;
    logic [IMG_H_W-1:0]  w_huse;
    logic [BPR_W-1:0]    w_bpr;
    logic signed [COORD_W:0] w_wz;
    logic signed [COORD_W:0] w_hz;
    logic signed [COORD_W:0] w_x;
    logic signed [COORD_W:0] w_y;
    logic signed [COORD_W:0] w_x1;
    logic signed [COORD_W:0] w_y1;
    logic signed [COORD_W:0] w_x0;
    logic signed [COORD_W:0] w_y0;
    logic signed [COORD_W:0] w_x1c;
    logic signed [COORD_W:0] w_y1c;
    logic signed [COORD_W:0] w_xl;
    logic signed [COORD_W:0] w_yl;
    logic                w_fill_empty;
    logic                w_read_in;
    logic [Y_W-1:0]      w_ysel;
    logic [RA_W-1:0]     w_prod;
    logic [RA_W-1:0]     w_addr;
    logic                w_addr_ok;
    logic [7:0]          w_lmask;
    logic [7:0]          w_rmask;
    logic [7:0]          w_mask;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [7:0]          w_wdata;
    logic                w_row_end;
    logic                w_out_free;

    assign w_wuse = (r_img_w > WMAX) ? WMAX : r_img_w;
    assign w_huse = (r_img_h > HMAX) ? HMAX : r_img_h;
    assign w_bpr  = BPR_W'((9'(w_wuse) + 9'd7) >> 3);

    assign w_wz  = $signed((COORD_W + 1)'(w_wuse));
    assign w_hz  = $signed((COORD_W + 1)'(w_huse));
    assign w_x   = {r_px[COORD_W-1], r_px};
    assign w_y   = {r_py[COORD_W-1], r_py};
    assign w_x1  = w_x + {r_rw[COORD_W-1], r_rw};
    assign w_y1  = w_y + {r_rh[COORD_W-1], r_rh};
    assign w_x0  = w_x[COORD_W] ? '0 : w_x;
    assign w_y0  = w_y[COORD_W] ? '0 : w_y;
    assign w_x1c = (w_x1 > w_wz) ? w_wz : w_x1;
    assign w_y1c = (w_y1 > w_hz) ? w_hz : w_y1;
    assign w_xl  = w_x1c - (COORD_W + 1)'(1);
    assign w_yl  = w_y1c - (COORD_W + 1)'(1);

    assign w_fill_empty = (r_rw <= 0) || (r_rh <= 0) || (w_x0 >= w_x1c) || (w_y0 >= w_y1c);
    assign w_read_in    = !w_x[COORD_W] && !w_y[COORD_W] && (w_x < w_wz) && (w_y < w_hz);

    assign w_ysel = (r_kind == KIND_FILL) ? w_y0[Y_W-1:0] : w_y[Y_W-1:0];
    assign w_prod = RA_W'(w_ysel) * RA_W'(w_bpr);

    assign w_addr    = r_row_base + RA_W'(r_bx);
    assign w_addr_ok = (w_addr < BUF_SIZE);

    assign w_lmask = (r_bx == r_x0[X_W-1:3]) ? (8'hFF >> r_x0[2:0]) : 8'hFF;
    assign w_rmask = (r_bx == r_xl[X_W-1:3]) ? (8'hFF << (3'd7 - r_xl[2:0])) : 8'hFF;
    assign w_mask  = w_lmask & w_rmask;

    assign w_we    = (r_state == S_CLR) || ((r_state == S_WR) && r_ok);
    assign w_waddr = (r_state == S_CLR) ? r_clr_addr : w_addr[ADDR_W-1:0];
    assign w_wdata = (r_state == S_CLR) ? r_fill :
                     (r_ink ? (r_rdata | w_mask) : (r_rdata & ~w_mask));

    assign w_row_end  = (r_bx == r_xl[X_W-1:3]);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_out_pix;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WMAX;
            r_img_h <= HMAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[IMG_H_W-1:0];
                default:          r_img_w <= r_img_w;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_addr   <= '0;
            r_fill       <= 8'h00;
            r_clr_result <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind  <= i_kind;
                        r_px    <= i_pos_x;
                        r_py    <= i_pos_y;
                        r_rw    <= i_rect_width;
                        r_rh    <= i_rect_height;
                        r_ink   <= i_ink;
                        r_pix   <= 1'b0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_row_base <= w_prod;
                    case (r_kind)
                        KIND_FILL: begin
                            r_x0    <= w_x0[X_W-1:0];
                            r_xl    <= w_xl[X_W-1:0];
                            r_cy    <= w_y0[Y_W-1:0];
                            r_yl    <= w_yl[Y_W-1:0];
                            r_bx    <= w_x0[X_W-1:3];
                            r_state <= w_fill_empty ? S_DONE : S_RD;
                        end
                        KIND_READ: begin
                            r_x0    <= w_x[X_W-1:0];
                            r_bx    <= w_x[X_W-1:3];
                            r_state <= w_read_in ? S_PRD : S_DONE;
                        end
                        KIND_CLEAR: begin
                            r_fill       <= {8{r_ink}};
                            r_clr_addr   <= '0;
                            r_clr_result <= 1'b1;
                            r_state      <= S_CLR;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RD: begin
                    r_ok    <= w_addr_ok;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (w_row_end) begin
                        if (r_cy == r_yl) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cy       <= r_cy + Y_W'(1);
                            r_row_base <= r_row_base + RA_W'(w_bpr);
                            r_bx       <= r_x0[X_W-1:3];
                            r_state    <= S_RD;
                        end
                    end else begin
                        r_bx    <= r_bx + BX_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_PRD: begin
                    r_ok    <= w_addr_ok;
                    r_state <= S_PGET;
                end
                S_PGET: begin
                    r_pix   <= r_ok && ((r_rdata & (8'h80 >> r_x0[2:0])) != 8'h00);
                    r_state <= S_DONE;
                end
                S_CLR: begin
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= r_clr_result ? S_DONE : S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_pix <= r_pix;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
